// File: hw/rtl/eefa_pkg.sv
// ----------------------------------------------------------------------------
// eefa_pkg
// Shared types and constants of the extended exponent float accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package eefa_pkg;

    localparam int unsigned FRAC_W  = 52;
    localparam int unsigned MANT_W  = 53;
    localparam int unsigned EXP_W   = 64;
    localparam int unsigned FIELD_W = 11;
    localparam int unsigned GUARD_W = 10;
    localparam int unsigned PROD_W  = 106;
    localparam int unsigned PART_W  = 27;

    localparam logic [11:0] EXP_BIAS  = 12'd1023;
    localparam logic [6:0]  FAR_LIMIT = 7'd64;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_ADD  = 2'd1,
        OP_MUL  = 2'd2,
        OP_NOP  = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode             op;
        logic [FRAC_W-1:0]   frac;
        logic [EXP_W-1:0]    exp;
    } t_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_ALIGN,
        S_ADD_SUM,
        S_MUL_PP,
        S_MUL_RND,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// File: hw/rtl/eefa_front.sv
// ----------------------------------------------------------------------------
// eefa_front
// Accepts operand beats, unpacks the double and folds its exponent field into
// the extra exponent, and holds the items in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module eefa_front
    import eefa_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [127:0] i_s_tdata,
    input  wire logic [1:0]  i_s_tuser,
    output logic             o_valid,
    output t_item            o_item,
    input  wire logic        i_pop
);

    t_item       r_q [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic [1:0]  n_count;
    logic        push;
    t_item       item_in;
    logic [10:0] field;
    logic [11:0] field_off;

    always_comb begin
        field          = i_s_tdata[62:52];
        field_off      = {1'b0, field} - EXP_BIAS;
        item_in.op     = t_opcode'(i_s_tuser);
        item_in.frac   = i_s_tdata[51:0];
        item_in.exp    = i_s_tdata[127:64] + {{52{field_off[11]}}, field_off};
    end

    assign o_s_tready = (r_count != 2'd2);
    assign push       = i_s_tvalid && o_s_tready;
    assign o_valid    = (r_count != 2'd0);
    assign o_item     = r_q[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= item_in;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/eefa_back.sv
// ----------------------------------------------------------------------------
// eefa_back
// Holds the accumulator and runs load, aligned add and multiply with
// round-to-nearest-even, then hands the new value to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module eefa_back
    import eefa_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    input  wire t_item        i_item,
    output logic              o_pop,
    output logic              o_finish,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [119:0]      o_m_tdata
);

    t_state              r_state;
    t_state              n_state;
    logic [FRAC_W-1:0]   r_acc_frac;
    logic [EXP_W-1:0]    r_acc_exp;
    logic [FRAC_W-1:0]   r_res_frac;
    logic [EXP_W-1:0]    r_res_exp;
    logic [MANT_W-1:0]   r_big;
    logic [MANT_W-1:0]   r_small;
    logic [6:0]          r_d;
    logic [EXP_W-1:0]    r_ebig;
    logic [63:0]         r_l;
    logic [63:0]         r_sh;
    logic [MANT_W-1:0]   r_ma;
    logic [MANT_W-1:0]   r_mb;
    logic [2:0]          r_cnt;
    logic [2*PART_W-1:0] r_pp;
    logic [1:0]          r_pp_sh;
    logic [PROD_W-1:0]   r_prod;
    logic [EXP_W-1:0]    r_esum;
    logic                r_out_valid;
    logic [119:0]        r_out_data;

    logic [EXP_W-1:0]    diff;
    logic                far_pos;
    logic                far_neg;
    logic [6:0]          nd;
    logic [MANT_W-1:0]   ma;
    logic [MANT_W-1:0]   mb;
    logic [63:0]         s64;
    logic [63:0]         mask;
    logic [63:0]         sh;
    logic [63:0]         sum;
    logic                a_top;
    logic [MANT_W-1:0]   a_q53;
    logic                a_up;
    logic [MANT_W:0]     a_q;
    logic [MANT_W-1:0]   m_q53;
    logic                m_up;
    logic [MANT_W:0]     m_q;
    logic [PART_W-1:0]   pa;
    logic [PART_W-1:0]   pb;
    logic [PROD_W-1:0]   pp_ext;
    logic                out_free;

    assign ma       = {1'b1, r_acc_frac};
    assign mb       = {1'b1, i_item.frac};
    assign diff     = r_acc_exp - i_item.exp;
    assign far_pos  = $signed(diff) > $signed(64'(FAR_LIMIT));
    assign far_neg  = $signed(diff) < -$signed(64'(FAR_LIMIT));
    assign nd       = 7'd0 - diff[6:0];
    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (i_item.op) inside
                        OP_LOAD, OP_NOP: n_state = S_DONE;
                        OP_ADD:          n_state = (far_pos || far_neg) ? S_DONE : S_ADD_ALIGN;
                        OP_MUL:          n_state = S_MUL_PP;
                        default:         n_state = S_DONE;
                    endcase
                end
            end
            S_ADD_ALIGN: n_state = S_ADD_SUM;
            S_ADD_SUM:   n_state = S_DONE;
            S_MUL_PP:    n_state = (r_cnt == 3'd4) ? S_MUL_RND : S_MUL_PP;
            S_MUL_RND:   n_state = S_DONE;
            S_DONE:      n_state = out_free ? S_IDLE : S_DONE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = (r_state == S_IDLE) && i_valid;
        o_finish = (r_state == S_DONE) && out_free;
    end

    always_comb begin
        s64  = {1'b0, r_small, 10'b0};
        mask = (64'd1 << r_d[5:0]) - 64'd1;
        if (r_d[6]) begin
            sh = 64'd1;
        end else if (r_d == 7'd0) begin
            sh = s64;
        end else begin
            sh = (s64 >> r_d[5:0]) | {63'd0, |(s64 & mask)};
        end

        sum   = r_l + r_sh;
        a_top = sum[63];
        a_q53 = a_top ? sum[63:11] : sum[62:10];
        a_up  = a_top ? (sum[10] && (|sum[9:0] || a_q53[0]))
                      : (sum[9] && (|sum[8:0] || a_q53[0]));
        a_q   = {1'b0, a_q53} + {{MANT_W{1'b0}}, a_up};

        m_q53 = r_prod[105] ? r_prod[105:53] : r_prod[104:52];
        m_up  = r_prod[105] ? (r_prod[52] && (|r_prod[51:0] || m_q53[0]))
                            : (r_prod[51] && (|r_prod[50:0] || m_q53[0]));
        m_q   = {1'b0, m_q53} + {{MANT_W{1'b0}}, m_up};

        pa = r_cnt[1] ? {1'b0, r_ma[52:27]} : r_ma[26:0];
        pb = r_cnt[0] ? {1'b0, r_mb[52:27]} : r_mb[26:0];

        unique case (r_pp_sh)
            2'd0:    pp_ext = {52'd0, r_pp};
            2'd1:    pp_ext = {25'd0, r_pp, 27'd0};
            default: pp_ext = {r_pp, 52'd0} << 2;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc_frac  <= '0;
            r_acc_exp   <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= 3'd0;
        end else begin
            r_state <= n_state;
            if (o_finish) begin
                r_acc_frac  <= r_res_frac;
                r_acc_exp   <= r_res_exp;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_MUL_PP) begin
                r_cnt <= r_cnt + 3'd1;
            end else begin
                r_cnt <= 3'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_finish) begin
            r_out_data <= {4'd0, r_res_exp, r_res_frac};
        end
        unique case (r_state)
            S_IDLE: begin
                r_ma   <= ma;
                r_mb   <= mb;
                r_esum <= r_acc_exp + i_item.exp;
                r_prod <= '0;
                if (!diff[63]) begin
                    r_big   <= ma;
                    r_small <= mb;
                    r_d     <= diff[6:0];
                    r_ebig  <= r_acc_exp;
                end else begin
                    r_big   <= mb;
                    r_small <= ma;
                    r_d     <= nd;
                    r_ebig  <= i_item.exp;
                end
                if (i_item.op == OP_LOAD || (i_item.op == OP_ADD && far_neg)) begin
                    r_res_frac <= i_item.frac;
                    r_res_exp  <= i_item.exp;
                end else begin
                    r_res_frac <= r_acc_frac;
                    r_res_exp  <= r_acc_exp;
                end
            end
            S_ADD_ALIGN: begin
                r_l  <= {1'b0, r_big, 10'b0};
                r_sh <= sh;
            end
            S_ADD_SUM: begin
                r_res_frac <= a_q[MANT_W] ? a_q[52:1] : a_q[51:0];
                r_res_exp  <= r_ebig + 64'(a_top) + 64'(a_q[MANT_W]);
            end
            S_MUL_PP: begin
                if (r_cnt != 3'd4) begin
                    r_pp    <= pa * pb;
                    r_pp_sh <= 2'(r_cnt[0]) + 2'(r_cnt[1]);
                end
                if (r_cnt != 3'd0) begin
                    r_prod <= r_prod + pp_ext;
                end
            end
            S_MUL_RND: begin
                r_res_frac <= m_q[MANT_W] ? m_q[52:1] : m_q[51:0];
                r_res_exp  <= r_esum + 64'(r_prod[105]) + 64'(m_q[MANT_W]);
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

`default_nettype wire

// File: hw/rtl/extended_exponent_float_accumulator.sv
// ----------------------------------------------------------------------------
// extended_exponent_float_accumulator
// Positive accumulator with a 53-bit significand and a 64-bit exponent that
// loads, adds or multiplies by operands given as double bits plus exponent.
//
// Channel  Dir  Payload
// s        in   tdata: operand_bits[63:0], operand_exp[127:64]; tuser: opcode
// m        out  tdata: result_fraction[51:0], result_exp[115:52], zero pad
//
// Load, no-op and an add of addends more than 64 binades apart skip the compute
// states; other adds pass through align and sum, multiply through the partial
// product and rounding states; the multiply uses one 27x27 multiplier four times.
// A two-entry queue keeps accepting beats while the back end works.
// Synchronous active-low reset clears the queue, the sequencer and sets the
// accumulator to 1.0 x 2^0. A stalled output holds the back end in its last step.
// ----------------------------------------------------------------------------
`default_nettype none

module extended_exponent_float_accumulator
    import eefa_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [127:0] i_s_tdata,   // operand_bits, operand_exp
    input  wire logic [1:0]   i_s_tuser,   // opcode
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [119:0]      o_m_tdata    // result_fraction, result_exp
);

    logic  q_valid;
    t_item q_item;
    logic  pop;
    logic  finish;

    eefa_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_valid    (q_valid),
        .o_item     (q_item),
        .i_pop      (pop)
    );

    eefa_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_item     (q_item),
        .o_pop      (pop),
        .o_finish   (finish),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid)
        else $error("queue popped while empty");

    a_finish_shows_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> o_m_tvalid)
        else $error("finished item not presented");

    a_no_pop_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |-> !pop)
        else $error("new item taken before result delivered");

endmodule

`default_nettype wire

// File: tb/tb_extended_exponent_float_accumulator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_extended_exponent_float_accumulator
// Streams load, add, multiply and no-op beats into the accumulator under
// random bursts and output stalls, predicts each accumulator value with a
// bit-exact model kept in the testbench and checks every result beat in order.
// ----------------------------------------------------------------------------

class acc_scoreboard;
    logic [51:0] acc_frac;
    logic [63:0] acc_exp;
    logic [51:0] want_frac_q[$];
    logic [63:0] want_exp_q[$];
    int          errors;

    function new();
        acc_frac = '0;
        acc_exp  = '0;
        errors   = 0;
    endfunction

    function logic [53:0] round_right(logic [63:0] v, int k);
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        q    = v >> k;
        rem  = v & ((64'd1 << k) - 64'd1);
        half = 64'd1 << (k - 1);
        if (rem > half || (rem == half && q[0])) q = q + 64'd1;
        return q[53:0];
    endfunction

    function void commit(logic [53:0] q, logic [63:0] e);
        if (q[53]) begin
            q = q >> 1;
            e = e + 64'd1;
        end
        acc_frac = q[51:0];
        acc_exp  = e;
    endfunction

    function void add_aligned(logic [52:0] big, logic [52:0] sml, int d, logic [63:0] e);
        logic [63:0] l;
        logic [63:0] s;
        logic [63:0] sh;
        logic [63:0] sum;
        l = {11'd0, big} << 10;
        s = {11'd0, sml} << 10;
        if (d >= 64) sh = 64'd1;
        else if (d == 0) sh = s;
        else begin
            sh = s >> d;
            if ((s & ((64'd1 << d) - 64'd1)) != 0) sh[0] = 1'b1;
        end
        sum = l + sh;
        if (sum[63]) commit(round_right(sum, 11), e + 64'd1);
        else commit(round_right(sum, 10), e);
    endfunction

    function void note_input(eefa_pkg::t_opcode op, logic [63:0] bits, logic [63:0] xexp);
        logic [51:0]  ofrac;
        logic [63:0]  oexp;
        logic [63:0]  diff;
        logic [63:0]  nd;
        logic [52:0]  ma;
        logic [52:0]  mb;
        logic [105:0] prod;
        logic [105:0] rem;
        logic [105:0] half;
        logic [53:0]  q;
        logic [63:0]  e;
        int           k;
        ofrac = bits[51:0];
        oexp  = xexp + {53'd0, bits[62:52]} - 64'd1023;
        ma    = {1'b1, acc_frac};
        mb    = {1'b1, ofrac};
        case (op)
            eefa_pkg::OP_LOAD: begin
                acc_frac = ofrac;
                acc_exp  = oexp;
            end
            eefa_pkg::OP_ADD: begin
                diff = acc_exp - oexp;
                if (!diff[63]) begin
                    if (diff <= 64) add_aligned(ma, mb, int'(diff), acc_exp);
                end else begin
                    nd = -diff;
                    if (nd > 64) begin
                        acc_frac = ofrac;
                        acc_exp  = oexp;
                    end else add_aligned(mb, ma, int'(nd), oexp);
                end
            end
            eefa_pkg::OP_MUL: begin
                e    = acc_exp + oexp;
                prod = ma * mb;
                k    = 52;
                if (prod[105]) begin
                    k = 53;
                    e = e + 64'd1;
                end
                q    = 54'(prod >> k);
                rem  = prod & ((106'd1 << k) - 106'd1);
                half = 106'd1 << (k - 1);
                if (rem > half || (rem == half && q[0])) q = q + 54'd1;
                commit(q, e);
            end
            default: ;
        endcase
        want_frac_q.push_back(acc_frac);
        want_exp_q.push_back(acc_exp);
    endfunction

    function void report(string what);
        errors++;
        $display("mismatch: %s", what);
    endfunction

    function void check_result(logic [119:0] data);
        logic [51:0] wf;
        logic [63:0] we;
        if (want_frac_q.size() == 0) begin
            report("result beat with nothing expected");
            return;
        end
        wf = want_frac_q.pop_front();
        we = want_exp_q.pop_front();
        if (data[51:0] !== wf)
            report($sformatf("fraction got %h want %h", data[51:0], wf));
        if (data[115:52] !== we)
            report($sformatf("exponent got %h want %h", data[115:52], we));
    endfunction
endclass

module tb_extended_exponent_float_accumulator;
    import eefa_pkg::*;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [127:0] i_s_tdata = '0;
    logic [1:0]   i_s_tuser = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [119:0] o_m_tdata;

    acc_scoreboard sb = new();
    int unsigned   cycles = 0;
    bit            stall_free = 1'b0;

    extended_exponent_float_accumulator dut (.*);

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
        if (!i_rst_n) i_m_tready <= 1'b0;
        else if (stall_free || (cycles % 512) < 128) i_m_tready <= 1'b1;
        else i_m_tready <= ($urandom_range(0, 3) != 0);
    end

    task automatic send(t_opcode op, logic [63:0] bits, logic [63:0] xexp);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {xexp, bits};
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_input(op, bits, xexp);
    endtask

    function automatic logic [63:0] rand_bits();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] near_exp();
        return 64'($signed($urandom_range(0, 160)) - 80);
    endfunction

    task automatic idle(int n);
        if (n > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    initial begin
        int          burst;
        logic [63:0] bits;
        logic [63:0] xexp;
        t_opcode     op;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(OP_NOP, 64'd0, 64'd0);
        send(OP_ADD, 64'h3FF0000000000000, 64'd0);
        send(OP_ADD, 64'h3FFFFFFFFFFFFFFF, 64'd0);
        send(OP_MUL, 64'hBFFFFFFFFFFFFFFF, 64'd0);
        send(OP_LOAD, 64'h0000000000000000, 64'd0);
        send(OP_LOAD, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF);
        send(OP_ADD, 64'h7FF0000000000001, 64'd0);
        send(OP_LOAD, 64'h3FF0000000000000, 64'd0);
        send(OP_ADD, 64'h3FF0000000000001, 64'd64);
        send(OP_ADD, 64'h3FF0000000000001, 64'd65);
        send(OP_ADD, 64'h3FF0000000000000, 64'hFFFFFFFFFFFFFF00);
        send(OP_ADD, 64'h3FFFFFFFFFFFFFFF, 64'd53);
        send(OP_ADD, 64'h3FF0000000000001, 64'd0);
        send(OP_LOAD, 64'h3FF0000000000000, 64'h7FFFFFFFFFFFFFFF);
        send(OP_ADD, 64'h3FF0000000000000, 64'h8000000000000000);
        send(OP_MUL, 64'h3FF8000000000000, 64'h7FFFFFFFFFFFFFFF);
        send(OP_MUL, 64'h3FFFFFFFFFFFFFFF, 64'h8000000000000000);
        send(OP_LOAD, 64'h3FF0000000000001, 64'd0);
        send(OP_MUL, 64'h3FFFFFFFFFFFFFFF, 64'd0);
        send(OP_MUL, 64'h7FEFFFFFFFFFFFFF, 64'd5);
        send(OP_NOP, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF);

        for (int n = 0; n < 1430; ) begin
            burst = (n >= 1000 && n < 1100) ? 100 : $urandom_range(1, 12);
            for (int b = 0; b < burst && n < 1430; b++, n++) begin
                op   = t_opcode'($urandom_range(0, 15) == 0 ? 3 : $urandom_range(0, 2));
                bits = rand_bits();
                case ($urandom_range(0, 7))
                    0: xexp = {$urandom, $urandom};
                    1: xexp = {1'b0, 63'h7FFFFFFFFFFFFF00} + 64'($urandom_range(0, 511));
                    default: begin
                        bits[62:52] = 11'd1023 + 11'($urandom_range(0, 20)) - 11'd10;
                        xexp = near_exp();
                    end
                endcase
                if ($urandom_range(0, 9) == 0) bits[51:0] = {52{$urandom_range(0, 1) == 1}};
                send(op, bits, xexp);
            end
            if (n > 1300) stall_free = 1'b1;
            if (burst != 100) idle($urandom_range(0, 6));
        end
        idle(1);

        while (sb.want_frac_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule
